/* hdl/cpsp_pkg.sv */
// Shared constants, types and character-class functions of the prototype span parser.
package cpsp_pkg;

  localparam int unsigned MaxLen = 4096;
  localparam int unsigned PosW   = $clog2(MaxLen + 1);
  localparam int unsigned FieldW = 12;
  localparam int unsigned ChW    = 8;

  typedef logic [PosW-1:0]   pos_t;
  typedef logic [FieldW-1:0] field_t;
  typedef logic [ChW-1:0]    char_t;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusFewTokens = 2'd1,
    StatusParen     = 2'd2,
    StatusTooLong   = 2'd3
  } status_e;

  typedef struct packed {
    status_e status;
    field_t  decl_start;
    field_t  decl_end;
    field_t  type_len;
    field_t  name_start;
    field_t  name_len;
    field_t  args_start;
    field_t  args_len;
  } result_t;

  localparam char_t ChNul   = 8'h00;
  localparam char_t ChTab   = 8'h09;
  localparam char_t ChLf    = 8'h0A;
  localparam char_t ChVt    = 8'h0B;
  localparam char_t ChCr    = 8'h0D;
  localparam char_t ChSpace = 8'h20;
  localparam char_t ChOpen  = 8'h28;
  localparam char_t ChClose = 8'h29;
  localparam char_t ChStar  = 8'h2A;
  localparam char_t ChSemi  = 8'h3B;
  localparam char_t ChUnder = 8'h5F;
  localparam char_t ChDig0  = 8'h30;
  localparam char_t ChDig9  = 8'h39;
  localparam char_t ChUpA   = 8'h41;
  localparam char_t ChUpZ   = 8'h5A;
  localparam char_t ChLoA   = 8'h61;
  localparam char_t ChLoZ   = 8'h7A;

  function automatic logic is_blank(char_t c);
    return (c == ChSpace) || (c == ChTab) || (c == ChVt) || (c == ChCr) || (c == ChLf);
  endfunction

  function automatic logic is_first(char_t c);
    return ((c >= ChUpA) && (c <= ChUpZ)) || ((c >= ChLoA) && (c <= ChLoZ)) ||
           (c == ChUnder) || (c == ChStar);
  endfunction

  function automatic logic is_follow(char_t c);
    return is_first(c) || ((c >= ChDig0) && (c <= ChDig9));
  endfunction

  // Fit a position into a result field: zero-extend or keep the low bits.
  function automatic field_t to_field(pos_t v);
    logic [PosW+FieldW-1:0] wide;
    wide = {{FieldW{1'b0}}, v};
    return wide[FieldW-1:0];
  endfunction

endpackage

/* hdl/cpsp_if.sv */
// Handshake interfaces for the character input and the result output.
interface cpsp_ch_if;
  logic                 valid;
  logic                 ready;
  cpsp_pkg::char_t      ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface cpsp_res_if;
  logic                 valid;
  logic                 ready;
  cpsp_pkg::status_e    status;
  cpsp_pkg::field_t     decl_start;
  cpsp_pkg::field_t     decl_end;
  cpsp_pkg::field_t     type_len;
  cpsp_pkg::field_t     name_start;
  cpsp_pkg::field_t     name_len;
  cpsp_pkg::field_t     args_start;
  cpsp_pkg::field_t     args_len;

  modport source (output valid, output status, output decl_start, output decl_end,
                  output type_len, output name_start, output name_len,
                  output args_start, output args_len, input ready);
  modport sink   (input valid, input status, input decl_start, input decl_end,
                  input type_len, input name_start, input name_len,
                  input args_start, input args_len, output ready);
endinterface

/* hdl/cpsp_core.sv */
// Parse state and one-character step logic of the prototype span parser.
module cpsp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  cpsp_pkg::char_t     ch_i,
  output logic                emit_o,
  output cpsp_pkg::result_t   result_o
);

  localparam logic [2:0] PhLead   = 3'd0;
  localparam logic [2:0] PhToken  = 3'd1;
  localparam logic [2:0] PhGap    = 3'd2;
  localparam logic [2:0] PhArgs   = 3'd3;
  localparam logic [2:0] PhAfter  = 3'd4;
  localparam logic [2:0] PhIgnore = 3'd5;

  localparam cpsp_pkg::pos_t PosLimit = cpsp_pkg::PosW'(cpsp_pkg::MaxLen);
  localparam cpsp_pkg::pos_t PosOne   = cpsp_pkg::PosW'(1);

  logic [2:0]      phase_q, phase_d;
  cpsp_pkg::pos_t  pos_q, pos_d;
  cpsp_pkg::pos_t  span_start_q, span_start_d;
  cpsp_pkg::pos_t  prev_end_q, prev_end_d;
  cpsp_pkg::pos_t  tok_start_q, tok_start_d;
  logic [1:0]      tok_cnt_q, tok_cnt_d;
  cpsp_pkg::pos_t  open_pos_q, open_pos_d;
  cpsp_pkg::pos_t  close_end_q, close_end_d;
  cpsp_pkg::pos_t  name_len_q, name_len_d;

  always_comb begin
    logic           err;
    logic           ok;
    logic           go_on;
    logic [2:0]     ph;
    cpsp_pkg::pos_t nl;
    cpsp_pkg::pos_t end_pos;
    cpsp_pkg::status_e err_st;

    err     = 1'b0;
    ok      = 1'b0;
    go_on   = 1'b1;
    ph      = phase_q;
    nl      = name_len_q;
    end_pos = pos_q;
    err_st  = cpsp_pkg::StatusOk;

    phase_d      = phase_q;
    pos_d        = pos_q;
    span_start_d = span_start_q;
    prev_end_d   = prev_end_q;
    tok_start_d  = tok_start_q;
    tok_cnt_d    = tok_cnt_q;
    open_pos_d   = open_pos_q;
    close_end_d  = close_end_q;
    name_len_d   = name_len_q;

    if (ph == PhIgnore || ph > PhIgnore) begin
      go_on   = 1'b0;
      phase_d = PhIgnore;
    end else if (pos_q >= PosLimit) begin
      go_on  = 1'b0;
      err    = 1'b1;
      err_st = cpsp_pkg::StatusTooLong;
    end else begin
      pos_d = pos_q + PosOne;
    end

    // Close a token on its first non-token character, then reclassify it.
    if (go_on && ph == PhToken) begin
      if (cpsp_pkg::is_follow(ch_i)) begin
        go_on = 1'b0;
      end else begin
        nl         = pos_q - tok_start_q;
        name_len_d = nl;
        ph         = PhGap;
        phase_d    = PhGap;
      end
    end

    if (go_on) begin
      case (ph)
        PhLead, PhGap: begin
          if (cpsp_pkg::is_blank(ch_i)) begin
            // skip
          end else if (cpsp_pkg::is_first(ch_i)) begin
            if (ph == PhLead) span_start_d = pos_q;
            else prev_end_d = tok_start_q + nl;
            tok_start_d = pos_q;
            if (tok_cnt_q < 2'd2) tok_cnt_d = tok_cnt_q + 2'd1;
            phase_d = PhToken;
          end else if (tok_cnt_q < 2'd2) begin
            err    = 1'b1;
            err_st = cpsp_pkg::StatusFewTokens;
          end else if (ch_i != cpsp_pkg::ChOpen) begin
            err    = 1'b1;
            err_st = cpsp_pkg::StatusParen;
          end else begin
            open_pos_d = pos_q;
            phase_d    = PhArgs;
          end
        end
        PhArgs: begin
          if (ch_i == cpsp_pkg::ChNul) begin
            err    = 1'b1;
            err_st = cpsp_pkg::StatusParen;
          end else if (ch_i == cpsp_pkg::ChClose) begin
            close_end_d = pos_q + PosOne;
            phase_d     = PhAfter;
          end
        end
        PhAfter: begin
          if (!cpsp_pkg::is_blank(ch_i)) begin
            end_pos = (ch_i == cpsp_pkg::ChSemi) ? pos_q + PosOne : pos_q;
            if (end_pos >= PosLimit) begin
              err    = 1'b1;
              err_st = cpsp_pkg::StatusTooLong;
            end else begin
              ok = 1'b1;
            end
          end
        end
        default: begin
          phase_d = PhIgnore;
        end
      endcase
    end

    result_o        = '0;
    result_o.status = err_st;
    if (ok) begin
      result_o.decl_start = cpsp_pkg::to_field(span_start_q);
      result_o.decl_end   = cpsp_pkg::to_field(end_pos);
      result_o.type_len   = cpsp_pkg::to_field(prev_end_q - span_start_q);
      result_o.name_start = cpsp_pkg::to_field(tok_start_q);
      result_o.name_len   = cpsp_pkg::to_field(name_len_q);
      result_o.args_start = cpsp_pkg::to_field(open_pos_q);
      result_o.args_len   = cpsp_pkg::to_field(close_end_q - open_pos_q);
    end
    emit_o = err || ok;

    // After a result, drop characters up to the terminating zero.
    if (emit_o) phase_d = PhIgnore;

    // A zero ends the string: restart from a clean parse.
    if ((emit_o || phase_d == PhIgnore) && ch_i == cpsp_pkg::ChNul) begin
      phase_d      = PhLead;
      pos_d        = '0;
      span_start_d = '0;
      prev_end_d   = '0;
      tok_start_d  = '0;
      tok_cnt_d    = '0;
      open_pos_d   = '0;
      close_end_d  = '0;
      name_len_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhLead;
      pos_q        <= '0;
      span_start_q <= '0;
      prev_end_q   <= '0;
      tok_start_q  <= '0;
      tok_cnt_q    <= '0;
      open_pos_q   <= '0;
      close_end_q  <= '0;
      name_len_q   <= '0;
    end else if (en_i) begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      span_start_q <= span_start_d;
      prev_end_q   <= prev_end_d;
      tok_start_q  <= tok_start_d;
      tok_cnt_q    <= tok_cnt_d;
      open_pos_q   <= open_pos_d;
      close_end_q  <= close_end_d;
      name_len_q   <= name_len_d;
    end
  end

endmodule

/* hdl/c_prototype_span_parser.sv */
// Top level of the C prototype span parser: input register, parse step, result register.
// Path: a character accepted into the input register is stepped by the core, which loads
//   its result word, if any, into the result register; the sink takes it from there.
// Throughput: one character word per cycle unless an untaken result stalls the step core.
// Reset: rst_ni is asynchronous and active low; it clears the parse state to the
//   leading-space phase at position zero and empties both registers. No clearing pass.
module c_prototype_span_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  cpsp_ch_if.sink     ch_i,
  cpsp_res_if.source  res_o
);

  // Input register: holds one character word until the core steps on it.
  logic              in_valid_q;
  cpsp_pkg::char_t   in_ch_q;

  // Result register: holds one result word until the sink takes it.
  logic              out_valid_q;
  cpsp_pkg::result_t out_res_q;

  logic              step_en;
  logic              emit;
  cpsp_pkg::result_t step_res;

  // Advance the core when a character is waiting and the result slot is
  // free or being drained this cycle; this keeps one word per cycle flowing.
  assign step_en    = in_valid_q && (!out_valid_q || res_o.ready);
  assign ch_i.ready = !in_valid_q || step_en;

  cpsp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (step_en),
    .ch_i     (in_ch_q),
    .emit_o   (emit),
    .result_o (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (ch_i.valid && ch_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (step_en) begin
      in_valid_q <= 1'b0;
    end
  end

  // Payload: load on acceptance only, no reset needed.
  always_ff @(posedge clk_i) begin
    if (ch_i.valid && ch_i.ready) begin
      in_ch_q <= ch_i.ch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_en && emit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en && emit) begin
      out_res_q <= step_res;
    end
  end

  // Drive the result channel from the result register.
  assign res_o.valid      = out_valid_q;
  assign res_o.status     = out_res_q.status;
  assign res_o.decl_start = out_res_q.decl_start;
  assign res_o.decl_end   = out_res_q.decl_end;
  assign res_o.type_len   = out_res_q.type_len;
  assign res_o.name_start = out_res_q.name_start;
  assign res_o.name_len   = out_res_q.name_len;
  assign res_o.args_start = out_res_q.args_start;
  assign res_o.args_len   = out_res_q.args_len;

endmodule
